// ===== sv/iss_pkg.sv =====
`default_nettype none

package iss_pkg;

    // Command codes
    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_REMOVE = 3'd1;
    localparam logic [2:0] CMD_READ   = 3'd2;
    localparam logic [2:0] CMD_SEARCH = 3'd3;
    localparam logic [2:0] CMD_DUMP   = 3'd4;

    // Status codes
    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_BAD_POS   = 3'd1;
    localparam logic [2:0] STATUS_FULL      = 3'd2;
    localparam logic [2:0] STATUS_NOT_FOUND = 3'd3;
    localparam logic [2:0] STATUS_EMPTY     = 3'd4;

    localparam int WORD_W = 32;
    localparam int POS_W  = 7;

    typedef struct packed {
        logic [2:0]               command;
        logic [POS_W-1:0]         position;
        logic signed [WORD_W-1:0] value;
    } iss_request_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] word;
        logic [POS_W-1:0]         found_position;
        logic [POS_W-1:0]         entry_count;
        logic [2:0]               status;
        logic                     last;
    } iss_result_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_INS_PUT,
        S_REM_RD,
        S_REM_WR,
        S_READ_OUT,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_DUMP_RD,
        S_DUMP_OUT
    } iss_state_t;

endpackage

`default_nettype wire

// ===== sv/iss_ram.sv =====
`default_nettype none

module iss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read one word with registered output
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/indexed_sequence_store_core.sv =====
`default_nettype none

// Ordered store of up to CAPACITY signed 32-bit words, addressed by 1-based position.
// Command channel: request is transferred at a rising edge with start high and busy low.
// busy stays high while a command walks the store; no new command is taken meanwhile.
// Result channel: each result sits on result for one cycle with result_strobe high and
// is transferred at the edge that ends that cycle; the receiver cannot stall it.
// result.last marks the final result of a command.
// Work after the transfer (n = entries held, p = position): rejected commands and
// unknown codes are answered from idle; read answers after its RAM read; remove moves
// n-p entries down; insert moves n-p+1 entries up, then writes the value; search
// compares entries up to the first match, at most n; dump gives n results.
// The steps follow from the registered RAM read: every entry moved or compared takes
// a read state, then a write or compare state.
// Reset clears the entry count and the sequencer; stored words are not cleared and
// are only read below the count.
module indexed_sequence_store_core
    import iss_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire iss_request_t request,
    output logic              result_strobe,
    output iss_result_t       result
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    iss_state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic signed [WORD_W-1:0] val_reg, val_next;
    iss_result_t result_reg, result_next;
    logic strobe_reg, strobe_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    logic [CW-1:0]    idx_dec;
    logic [CW-1:0]    idx_inc;
    logic [CW-1:0]    pos_dec;
    logic [POS_W-1:0] cnt_ext;
    logic [POS_W-1:0] req_pos_dec;
    logic [CW-1:0]    req_pos;
    logic             accept;

    assign idx_dec     = idx_reg - 1'b1;
    assign idx_inc     = idx_reg + 1'b1;
    assign pos_dec     = pos_reg - 1'b1;
    assign cnt_ext     = POS_W'(cnt_reg);
    assign req_pos_dec = request.position - 1'b1;
    assign req_pos     = CW'(request.position);
    assign accept      = start && (state_reg == S_IDLE);

    iss_ram #(
        .WIDTH(WORD_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            strobe_reg <= strobe_next;
        end
    end

    // Hold working registers and the result
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        result_reg <= result_next;
    end

    // Sequence commands over the RAM
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        result_next = result_reg;
        strobe_next = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = idx_reg[AW-1:0];
        ram_wdata   = ram_rdata;
        ram_raddr   = idx_dec[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                ram_raddr = req_pos_dec[AW-1:0];
                if (accept)
                begin
                    pos_next                   = req_pos;
                    val_next                   = request.value;
                    result_next.word           = '0;
                    result_next.found_position = '0;
                    result_next.entry_count    = cnt_ext;
                    result_next.status         = STATUS_OK;
                    result_next.last           = 1'b1;
                    unique case (request.command)
                        CMD_INSERT:
                        begin
                            if (cnt_reg == CW'(CAPACITY))
                            begin
                                result_next.status = STATUS_FULL;
                                strobe_next        = 1'b1;
                            end
                            else if (request.position == '0
                                     || request.position > cnt_ext + 1'b1)
                            begin
                                result_next.status = STATUS_BAD_POS;
                                strobe_next        = 1'b1;
                            end
                            else
                            begin
                                idx_next   = cnt_reg;
                                state_next = (cnt_reg >= req_pos) ? S_INS_RD : S_INS_PUT;
                            end
                        end
                        CMD_REMOVE, CMD_READ:
                        begin
                            if (cnt_reg == '0)
                            begin
                                result_next.status = STATUS_EMPTY;
                                strobe_next        = 1'b1;
                            end
                            else if (request.position == '0 || request.position > cnt_ext)
                            begin
                                result_next.status = STATUS_BAD_POS;
                                strobe_next        = 1'b1;
                            end
                            else if (request.command == CMD_READ)
                            begin
                                state_next = S_READ_OUT;
                            end
                            else if (req_pos < cnt_reg)
                            begin
                                idx_next   = req_pos;
                                state_next = S_REM_RD;
                            end
                            else
                            begin
                                cnt_next                = cnt_reg - 1'b1;
                                result_next.entry_count = POS_W'(cnt_next);
                                strobe_next             = 1'b1;
                            end
                        end
                        CMD_SEARCH:
                        begin
                            if (cnt_reg == '0)
                            begin
                                result_next.status = STATUS_EMPTY;
                                strobe_next        = 1'b1;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_SRCH_RD;
                            end
                        end
                        CMD_DUMP:
                        begin
                            if (cnt_reg == '0)
                            begin
                                result_next.status = STATUS_EMPTY;
                                strobe_next        = 1'b1;
                            end
                            else
                            begin
                                idx_next   = cnt_reg;
                                state_next = S_DUMP_RD;
                            end
                        end
                        default:
                        begin
                            strobe_next = 1'b1;
                        end
                    endcase
                end
            end

            // Move entry idx-1 up to idx, from the top down to the position
            S_INS_RD:
            begin
                ram_raddr  = idx_dec[AW-1:0];
                state_next = S_INS_WR;
            end
            S_INS_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg[AW-1:0];
                ram_wdata  = ram_rdata;
                idx_next   = idx_dec;
                state_next = (idx_dec >= pos_reg) ? S_INS_RD : S_INS_PUT;
            end
            S_INS_PUT:
            begin
                ram_we                  = 1'b1;
                ram_waddr               = pos_dec[AW-1:0];
                ram_wdata               = val_reg;
                cnt_next                = cnt_reg + 1'b1;
                result_next.entry_count = POS_W'(cnt_next);
                strobe_next             = 1'b1;
                state_next              = S_IDLE;
            end

            // Move entry idx down to idx-1, from the position up to the top
            S_REM_RD:
            begin
                ram_raddr  = idx_reg[AW-1:0];
                state_next = S_REM_WR;
            end
            S_REM_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_dec[AW-1:0];
                ram_wdata = ram_rdata;
                idx_next  = idx_inc;
                if (idx_inc < cnt_reg)
                begin
                    state_next = S_REM_RD;
                end
                else
                begin
                    cnt_next                = cnt_reg - 1'b1;
                    result_next.entry_count = POS_W'(cnt_next);
                    strobe_next             = 1'b1;
                    state_next              = S_IDLE;
                end
            end

            // Return the addressed entry in word
            S_READ_OUT:
            begin
                result_next.word = ram_rdata;
                strobe_next      = 1'b1;
                state_next       = S_IDLE;
            end

            // Read, then compare, one entry at a time, lowest position first
            S_SRCH_RD:
            begin
                ram_raddr  = idx_reg[AW-1:0];
                state_next = S_SRCH_CMP;
            end
            S_SRCH_CMP:
            begin
                idx_next = idx_inc;
                if (ram_rdata == val_reg)
                begin
                    result_next.found_position = POS_W'(idx_inc);
                    strobe_next                = 1'b1;
                    state_next                 = S_IDLE;
                end
                else if (idx_inc == cnt_reg)
                begin
                    result_next.status = STATUS_NOT_FOUND;
                    strobe_next        = 1'b1;
                    state_next         = S_IDLE;
                end
                else
                begin
                    state_next = S_SRCH_RD;
                end
            end

            // Emit entries from the last position down to the first
            S_DUMP_RD:
            begin
                ram_raddr  = idx_dec[AW-1:0];
                state_next = S_DUMP_OUT;
            end
            S_DUMP_OUT:
            begin
                result_next.word = ram_rdata;
                result_next.last = (idx_reg == CW'(1));
                strobe_next      = 1'b1;
                idx_next         = idx_dec;
                state_next       = (idx_reg == CW'(1)) ? S_IDLE : S_DUMP_RD;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy          = (state_reg != S_IDLE);
    assign result_strobe = strobe_reg;
    assign result        = result_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_transfer_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || result_strobe)
        else $error("command transfer neither answered nor in progress");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && result.last |-> !busy)
        else $error("final result while still busy");

    a_partial_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !result.last |-> busy)
        else $error("non-final result with sequencer idle");

    a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> result.entry_count == POS_W'(cnt_reg))
        else $error("reported entry count differs from held count");
`endif

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import iss_pkg::*;

    localparam int CAPACITY = 16;
    // Codes outside the command set, which the block answers without change
    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;
    localparam int RANDOM_COMMANDS = 420;
    localparam int SETTLE_CYCLES = 64;

    typedef struct {
        iss_request_t req;
        bit           drain;
    } pending_item_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         start = 1'b0;
    logic         busy;
    iss_request_t request = '0;
    logic         result_strobe;
    iss_result_t  result;

    pending_item_t pending_commands[$];
    iss_result_t   expected_results[$];

    // Shadow copy of the sequence held by the block
    logic signed [WORD_W-1:0] store_words[CAPACITY];
    int unsigned              store_count = 0;

    int mismatch_count = 0;
    int commands_taken = 0;

    indexed_sequence_store_core #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .result_strobe(result_strobe),
        .result(result)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic iss_result_t make_result(logic signed [WORD_W-1:0] word,
                                                int unsigned found, logic [2:0] status,
                                                logic last);
        iss_result_t r;
        r.word           = word;
        r.found_position = POS_W'(found);
        r.entry_count    = POS_W'(store_count);
        r.status         = status;
        r.last           = last;
        return r;
    endfunction

    // Apply one command to the shadow store and queue the results it causes
    function automatic void predict_command(iss_request_t req);
        int unsigned pos;
        int          i;
        bit          hit;
        pos = req.position;
        hit = 1'b0;
        case (req.command)
            CMD_INSERT:
            begin
                if (store_count >= CAPACITY)
                    expected_results.push_back(make_result(0, 0, STATUS_FULL, 1'b1));
                else if (pos == 0 || pos > store_count + 1)
                    expected_results.push_back(make_result(0, 0, STATUS_BAD_POS, 1'b1));
                else
                begin
                    for (i = store_count; i >= int'(pos); i--)
                        store_words[i] = store_words[i-1];
                    store_words[pos-1] = req.value;
                    store_count++;
                    expected_results.push_back(make_result(0, 0, STATUS_OK, 1'b1));
                end
            end
            CMD_REMOVE:
            begin
                if (store_count == 0)
                    expected_results.push_back(make_result(0, 0, STATUS_EMPTY, 1'b1));
                else if (pos == 0 || pos > store_count)
                    expected_results.push_back(make_result(0, 0, STATUS_BAD_POS, 1'b1));
                else
                begin
                    for (i = pos; i < int'(store_count); i++)
                        store_words[i-1] = store_words[i];
                    store_count--;
                    expected_results.push_back(make_result(0, 0, STATUS_OK, 1'b1));
                end
            end
            CMD_READ:
            begin
                if (store_count == 0)
                    expected_results.push_back(make_result(0, 0, STATUS_EMPTY, 1'b1));
                else if (pos == 0 || pos > store_count)
                    expected_results.push_back(make_result(0, 0, STATUS_BAD_POS, 1'b1));
                else
                    expected_results.push_back(
                        make_result(store_words[pos-1], 0, STATUS_OK, 1'b1));
            end
            CMD_SEARCH:
            begin
                if (store_count == 0)
                    expected_results.push_back(make_result(0, 0, STATUS_EMPTY, 1'b1));
                else
                begin
                    for (i = 0; i < int'(store_count) && !hit; i++)
                    begin
                        if (store_words[i] == req.value)
                        begin
                            expected_results.push_back(make_result(0, i + 1, STATUS_OK, 1'b1));
                            hit = 1'b1;
                        end
                    end
                    if (!hit)
                        expected_results.push_back(
                            make_result(0, 0, STATUS_NOT_FOUND, 1'b1));
                end
            end
            CMD_DUMP:
            begin
                if (store_count == 0)
                    expected_results.push_back(make_result(0, 0, STATUS_EMPTY, 1'b1));
                else
                    for (i = store_count - 1; i >= 0; i--)
                        expected_results.push_back(
                            make_result(store_words[i], 0, STATUS_OK, i == 0));
            end
            default:
                expected_results.push_back(make_result(0, 0, STATUS_OK, 1'b1));
        endcase
    endfunction

    // Drive commands: advance on each transfer, idle at random, hold for a drain
    always @(posedge clk or negedge rst_n)
    begin : drive_commands
        logic          took;
        logic          drained;
        logic          quiet;
        logic          idle;
        pending_item_t nxt;
        if (!rst_n)
        begin
            start   <= 1'b0;
            request <= '0;
        end
        else
        begin
            took    = start && !busy;
            // a result strobed at this edge is counted as gone, whichever block runs first
            drained = (expected_results.size() <= int'(result_strobe)) && !took;
            if (took)
            begin
                predict_command(request);
                commands_taken++;
            end
            if (!start || took)
            begin
                quiet = commands_taken >= 180 && commands_taken < 260;
                idle  = !quiet && ($urandom_range(0, 99) < 37);
                if (pending_commands.size() > 0 && !idle &&
                    (!pending_commands[0].drain || drained))
                begin
                    nxt = pending_commands.pop_front();
                    start   <= 1'b1;
                    request <= nxt.req;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    task automatic check_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Compare every strobed result with the oldest expectation
    always @(posedge clk)
    begin : watch_results
        iss_result_t want;
        if (rst_n && result_strobe)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: word 0x%0h status %0d", result.word, result.status);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("word", want.word, result.word);
                check_field("found_position", want.found_position, result.found_position);
                check_field("entry_count", want.entry_count, result.entry_count);
                check_field("status", want.status, result.status);
                check_field("last", want.last, result.last);
            end
        end
    end

    task automatic queue_command(logic [2:0] cmd, int unsigned pos,
                                 logic signed [WORD_W-1:0] value, bit drain);
        pending_item_t item;
        item.req.command  = cmd;
        item.req.position = POS_W'(pos);
        item.req.value    = value;
        item.drain        = drain;
        pending_commands.push_back(item);
    endtask

    // Build the command list, release reset, then wait for the block to settle
    initial
    begin : stimulus
        logic signed [WORD_W-1:0] value_pool[8];
        logic signed [WORD_W-1:0] value;
        logic [2:0]               cmd;
        int unsigned              pos;
        int unsigned              gen_count;
        int                       n;
        int                       roll;
        bit                       fill_phase;

        // Empty store on every command that looks at it
        queue_command(CMD_READ, 1, 0, 1'b0);
        queue_command(CMD_REMOVE, 1, 0, 1'b0);
        queue_command(CMD_SEARCH, 0, 0, 1'b0);
        queue_command(CMD_DUMP, 0, 0, 1'b0);
        // Bad insert positions, then inserts at front, end and middle
        queue_command(CMD_INSERT, 0, 5, 1'b0);
        queue_command(CMD_INSERT, 2, 5, 1'b0);
        queue_command(CMD_INSERT, 1, 32'sh7FFF_FFFF, 1'b0);
        queue_command(CMD_INSERT, 1, 32'sh8000_0000, 1'b0);
        queue_command(CMD_INSERT, 3, -1, 1'b0);
        queue_command(CMD_INSERT, 2, 0, 1'b0);
        // Reads in and out of range
        queue_command(CMD_READ, 0, 0, 1'b0);
        queue_command(CMD_READ, 5, 0, 1'b0);
        queue_command(CMD_READ, 4, 0, 1'b0);
        queue_command(CMD_READ, 64, 0, 1'b0);
        // Search hit and miss, then a full dump
        queue_command(CMD_SEARCH, 0, -1, 1'b0);
        queue_command(CMD_SEARCH, 127, 12345, 1'b0);
        queue_command(CMD_DUMP, 0, 0, 1'b0);
        // Bad and good removes
        queue_command(CMD_REMOVE, 0, 0, 1'b0);
        queue_command(CMD_REMOVE, 64, 0, 1'b0);
        queue_command(CMD_REMOVE, 2, 0, 1'b0);
        // Unknown codes
        for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++)
            queue_command(3'(c), 64, $urandom, 1'b0);

        // Small pool so that searches hit and duplicates occur
        value_pool[0] = 32'sh7FFF_FFFF;
        value_pool[1] = 32'sh8000_0000;
        value_pool[2] = 0;
        value_pool[3] = -1;
        for (int k = 4; k < 8; k++)
            value_pool[k] = $urandom;

        // Alternate fill-heavy and drain-heavy phases, mostly well-formed positions
        gen_count = 3;
        for (n = 0; n < RANDOM_COMMANDS; n++)
        begin
            fill_phase = ((n / 40) % 2) == 0;
            roll  = $urandom_range(0, 99);
            value = $urandom_range(0, 1) ? value_pool[$urandom_range(0, 7)] : $urandom;
            if ($urandom_range(0, 9) == 0)
            begin
                cmd = 3'($urandom_range(0, 7));
                pos = $urandom_range(0, 64);
            end
            else if (roll < (fill_phase ? 55 : 20))
            begin
                cmd = CMD_INSERT;
                pos = $urandom_range(1, gen_count + 1);
            end
            else if (roll < (fill_phase ? 65 : 60))
            begin
                cmd = CMD_REMOVE;
                pos = $urandom_range(1, gen_count > 0 ? gen_count : 1);
            end
            else if (roll < 78)
            begin
                cmd = CMD_READ;
                pos = $urandom_range(1, gen_count > 0 ? gen_count : 1);
            end
            else if (roll < 92)
            begin
                cmd = CMD_SEARCH;
                pos = $urandom_range(0, 64);
            end
            else
            begin
                cmd = CMD_DUMP;
                pos = $urandom_range(0, 64);
            end
            // track the fill level to keep positions in range
            if (cmd == CMD_INSERT && gen_count < CAPACITY && pos >= 1 && pos <= gen_count + 1)
                gen_count++;
            else if (cmd == CMD_REMOVE && gen_count > 0 && pos >= 1 && pos <= gen_count)
                gen_count--;
            queue_command(cmd, pos, value, n == 0 || n == 200 || n == 330);
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_commands.size() > 0 || start)
            @(posedge clk);
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== indexed_sequence_store_core.f =====
sv/iss_pkg.sv
sv/iss_ram.sv
sv/indexed_sequence_store_core.sv
bench/testbench.sv
